@@ hdl/fts_pkg.sv @@
`timescale 1ns / 1ps

package fts_pkg;

  localparam int SectorBytes      = 512;
  localparam int EntriesPerSector = SectorBytes / 2;
  localparam int BeatsPerSector   = (SectorBytes + 7) / 8;
  localparam int BeatW            = (BeatsPerSector > 1) ? $clog2(BeatsPerSector) : 1;
  localparam int PosW             = BeatW + 2;
  localparam int QueueDepth       = 2;
  localparam int QueuePtrW        = $clog2(QueueDepth);
  localparam int QueueCntW        = $clog2(QueueDepth + 1);

  localparam int EntryW  = 16;
  localparam int CfgIdxW = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_FIRST_END    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SECOND_START = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_SECOND_END   = 2'd2;

  localparam logic [EntryW-1:0] FIRST_END_RESET = 16'd3;
  localparam logic [EntryW-1:0] MEDIA_ENTRY0    = 16'hFFF8;
  localparam logic [EntryW-1:0] MEDIA_ENTRY1    = 16'hFFFF;
  localparam logic [EntryW-1:0] END_OF_CHAIN    = 16'hFFFF;
  localparam logic [EntryW-1:0] FREE_ENTRY      = 16'h0000;

  typedef struct packed {
    logic [EntryW-1:0] first_end;
    logic [EntryW-1:0] second_start;
    logic [EntryW-1:0] second_end;
  } cfg_t;

  // A classified request: first cluster index of the sector, and whether
  // the sector carries the media entries.
  typedef struct packed {
    logic [EntryW-1:0] base;
    logic              sec0;
  } job_t;

  typedef struct packed {
    logic             busy;
    logic [BeatW-1:0] beat;
  } back_status_t;

  function automatic logic [EntryW-1:0] entry_value(
    input logic [EntryW-1:0] base,
    input logic [PosW-1:0]   pos,
    input logic              sec0,
    input cfg_t              cfg
  );
    logic [EntryW-1:0] k;
    logic              in_body;
    logic [EntryW-1:0] res;
    k       = base + EntryW'(pos);
    in_body = (k < cfg.first_end) ||
              ((k >= cfg.second_start) && (k < cfg.second_end));
    if (32'(pos) >= EntriesPerSector) begin
      res = FREE_ENTRY;
    end else if (sec0 && (pos == PosW'(0))) begin
      res = MEDIA_ENTRY0;
    end else if (sec0 && (pos == PosW'(1))) begin
      res = MEDIA_ENTRY1;
    end else if (in_body) begin
      res = k + EntryW'(1);
    end else if ((k == cfg.first_end) || (k == cfg.second_end)) begin
      res = END_OF_CHAIN;
    end else begin
      res = FREE_ENTRY;
    end
    return res;
  endfunction

endpackage

@@ hdl/fts_front.sv @@
`timescale 1ns / 1ps

module fts_front (
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           fat_sector_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output fts_pkg::job_t        job_o
);

  logic [31:0] base_wide;

  // The first cluster index of a sector is cut to 16 bits; an 8-bit sector number never makes it wrap.
  assign base_wide  = 32'(fat_sector_i) * 32'(fts_pkg::EntriesPerSector);
  assign job_o.base = base_wide[fts_pkg::EntryW-1:0];
  assign job_o.sec0 = (fat_sector_i == 8'd0);

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

endmodule

@@ hdl/fts_queue.sv @@
`timescale 1ns / 1ps

module fts_queue (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  input  fts_pkg::job_t                     push_data_i,
  input  logic                              pop_i,
  output logic                              valid_o,
  output fts_pkg::job_t                     head_o,
  output logic                              full_o,
  output logic [fts_pkg::QueueCntW-1:0]     count_o
);

  fts_pkg::job_t                     slot_q [fts_pkg::QueueDepth];
  logic [fts_pkg::QueuePtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [fts_pkg::QueuePtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [fts_pkg::QueueCntW-1:0]     count_q, count_d;
  logic                              do_push, do_pop;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == fts_pkg::QueueCntW'(fts_pkg::QueueDepth));
  assign head_o  = slot_q[rd_ptr_q];
  assign count_o = count_q;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (32'(wr_ptr_q) == fts_pkg::QueueDepth - 1) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (32'(rd_ptr_q) == fts_pkg::QueueDepth - 1) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ hdl/fts_back.sv @@
`timescale 1ns / 1ps

module fts_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  fts_pkg::cfg_t              cfg_i,
  input  logic                       q_valid_i,
  input  fts_pkg::job_t              q_head_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [15:0]                entry_a_o,
  output logic [15:0]                entry_b_o,
  output logic [15:0]                entry_c_o,
  output logic [15:0]                entry_d_o,
  output logic                       final_beat_o,
  output fts_pkg::back_status_t      status_o
);

  logic                          busy_q, busy_d;
  logic [fts_pkg::BeatW-1:0]     beat_q, beat_d;
  fts_pkg::job_t                 job_q, job_d;
  logic                          out_valid_q;
  logic [fts_pkg::EntryW-1:0]    ent_q [4];
  logic [fts_pkg::EntryW-1:0]    ent_d [4];
  logic                          final_q;
  logic                          advance, last_beat, load;

  assign advance   = !out_valid_q || out_ready_i;
  assign last_beat = (32'(beat_q) == fts_pkg::BeatsPerSector - 1);
  // Take the next sector as the current one hands over its last word, so
  // consecutive sectors run without a gap.
  assign load      = advance && q_valid_i && (!busy_q || last_beat);
  assign pop_o     = load;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      ent_d[j] = fts_pkg::entry_value(job_q.base, {beat_q, 2'(j)}, job_q.sec0, cfg_i);
    end
  end

  always_comb begin
    busy_d = busy_q;
    beat_d = beat_q;
    job_d  = job_q;
    if (advance) begin
      if (busy_q && !last_beat) begin
        beat_d = beat_q + 1'b1;
      end else begin
        busy_d = q_valid_i;
        beat_d = '0;
        if (load) begin
          job_d = q_head_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      beat_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      beat_q <= beat_d;
      if (advance) begin
        out_valid_q <= busy_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    if (advance) begin
      for (int j = 0; j < 4; j++) begin
        ent_q[j] <= ent_d[j];
      end
      final_q <= last_beat;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign entry_a_o     = ent_q[0];
  assign entry_b_o     = ent_q[1];
  assign entry_c_o     = ent_q[2];
  assign entry_d_o     = ent_q[3];
  assign final_beat_o  = final_q;
  assign status_o.busy = busy_q;
  assign status_o.beat = beat_q;

endmodule

@@ hdl/fat16_table_sector_generator.sv @@
`timescale 1ns / 1ps

// Builds one sector of a virtual FAT16 table per request word and sends it
// as 64 output words of four little-endian entries (entry_a first), the last
// marked by final_beat_o. It sustains one output word per cycle while
// out_ready_i is high, from the entry generator behind a single output
// register. A request arriving while the generator is idle passes through
// the queue and the job register before its first word; requests queued
// behind a running sector follow with no gap. A two-word request queue lets
// in_valid_i be taken while a sector is still being produced. The chain
// registers must only be written while no sector is in flight.
module fat16_table_sector_generator (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [7:0]   fat_sector_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [15:0]  entry_a_o,
  output logic [15:0]  entry_b_o,
  output logic [15:0]  entry_c_o,
  output logic [15:0]  entry_d_o,
  output logic         final_beat_o,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [15:0]  cfg_data_i
);

  fts_pkg::cfg_t                       cfg_q;
  fts_pkg::job_t                       push_job, head_job;
  logic                                push, pop, q_valid, q_full;
  logic [fts_pkg::QueueCntW-1:0]       q_count;
  fts_pkg::back_status_t               back_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_end    <= fts_pkg::FIRST_END_RESET;
      cfg_q.second_start <= '0;
      cfg_q.second_end   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fts_pkg::REG_FIRST_END:    cfg_q.first_end    <= cfg_data_i;
        fts_pkg::REG_SECOND_START: cfg_q.second_start <= cfg_data_i;
        fts_pkg::REG_SECOND_END:   cfg_q.second_end   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  fts_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .fat_sector_i (fat_sector_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .job_o        (push_job)
  );

  fts_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (head_job),
    .full_o      (q_full),
    .count_o     (q_count)
  );

  fts_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .q_valid_i    (q_valid),
    .q_head_i     (head_job),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .entry_a_o    (entry_a_o),
    .entry_b_o    (entry_b_o),
    .entry_c_o    (entry_c_o),
    .entry_d_o    (entry_d_o),
    .final_beat_o (final_beat_o),
    .status_o     (back_status)
  );

  // An accepted request is held in the queue until the generator takes it.
  a_accept_queued : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (q_count != '0))
    else $error("accepted request not held in queue");

  a_idle_beat_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !back_status.busy |-> (back_status.beat == '0))
    else $error("beat counter not at zero while idle");

  a_pop_only_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid)
    else $error("queue popped while empty");

  a_final_follows_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !final_beat_o) |=> out_valid_o)
    else $error("sector output broke off before its final word");

endmodule
